FILE: rtl/core/mck_pkg.sv
// Shared definitions for the Monod cell kinetics pipeline: widths, fixed-point
// constants, register indexes and the structs passed between stages.
// No dependencies.
package mck_pkg;

   localparam int unsigned CONC_W     = 32;   // Q16.16 concentrations
   localparam int unsigned RATE_W     = 32;   // Q8.24 rates
   localparam int unsigned SUC_W      = 16;   // Q0.16 export fraction
   localparam int unsigned QUO_W      = 25;   // Monod factor, up to 1.0 in Q0.24
   localparam int unsigned DEN_W      = 33;   // K + x
   localparam int unsigned REM_W      = 34;   // partial remainder, below 2*den
   localparam int unsigned DIV_STEPS  = 25;   // one quotient bit per stage
   localparam int unsigned DIV_STAGES = DIV_STEPS + 1;
   localparam int unsigned DIS_W      = 24;   // dissolution term, signed
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Q0.32 constants
   localparam logic [14:0] KD_Q32   = 15'd18898;        // 4.4e-6
   localparam logic [31:0] K727_Q32 = 32'd3122441224;   // 0.727
   localparam logic [28:0] K100_Q32 = 29'd429496730;    // 0.1
   localparam logic [31:0] K650_Q32 = 32'd2791728742;   // 0.65
   localparam logic [29:0] K200_Q32 = 30'd858993459;    // 0.2

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_GROWTH = 3'd0,
      CSR_INV_YIELD  = 3'd1,
      CSR_LIGHT_K    = 3'd2,
      CSR_CO2_K      = 3'd3,
      CSR_MAINT      = 3'd4,
      CSR_DECAY      = 3'd5,
      CSR_SUC_EXPORT = 3'd6,
      CSR_GAS_EN     = 3'd7
   } csr_index_type;

   // cell data that rides alongside the dividers
   typedef struct packed {
      logic                      ghost;
      logic [CONC_W-1:0]         biomass;
      logic signed [DIS_W-1:0]   dis;
   } side_type;

   // configuration seen by the rate stages
   typedef struct packed {
      logic [RATE_W-1:0] max_growth;
      logic [RATE_W-1:0] inv_yield;
      logic [RATE_W-1:0] maint;
      logic [RATE_W-1:0] decay;
      logic [SUC_W-1:0]  suc_export;
      logic              gas_en;
   } rate_cfg_type;

endpackage

FILE: rtl/core/mck_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on mck_pkg.
interface mck_req_if;
   logic                       valid;
   logic                       ready;
   logic [mck_pkg::CONC_W-1:0] light_conc;
   logic [mck_pkg::CONC_W-1:0] co2_conc;
   logic [mck_pkg::CONC_W-1:0] gas_co2_conc;
   logic [mck_pkg::CONC_W-1:0] biomass_density;
   logic                       ghost_cell;

   modport source (output valid, light_conc, co2_conc, gas_co2_conc, biomass_density,
                   ghost_cell, input ready);
   modport sink   (input valid, light_conc, co2_conc, gas_co2_conc, biomass_density,
                   ghost_cell, output ready);
endinterface

interface mck_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [mck_pkg::RATE_W-1:0] light_reaction;
   logic signed [mck_pkg::RATE_W-1:0] co2_reaction;
   logic signed [mck_pkg::RATE_W-1:0] o2_reaction;
   logic signed [mck_pkg::RATE_W-1:0] sucrose_reaction;
   logic signed [mck_pkg::RATE_W-1:0] growth_rate;
   logic                              updated;

   modport source (output valid, light_reaction, co2_reaction, o2_reaction,
                   sucrose_reaction, growth_rate, updated, input ready);
   modport sink   (input valid, light_reaction, co2_reaction, o2_reaction,
                   sucrose_reaction, growth_rate, updated, output ready);
endinterface

interface mck_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mck_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [mck_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/core/mck_monod_div.sv
// Two-lane pipelined restoring divider forming x*2^24/(K+x) for light and CO2,
// one quotient bit per stage, with the cell sideband carried alongside.
// Depends on mck_pkg.
module mck_monod_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [mck_pkg::CONC_W-1:0]       light_conc,
   input  logic [mck_pkg::CONC_W-1:0]       co2_conc,
   input  logic [mck_pkg::CONC_W-1:0]       light_k,
   input  logic [mck_pkg::CONC_W-1:0]       co2_k,
   input  mck_pkg::side_type                entry_side,
   output logic                             out_valid,
   output logic [mck_pkg::QUO_W-1:0]        light_frac,
   output logic [mck_pkg::QUO_W-1:0]        co2_frac,
   output mck_pkg::side_type                exit_side
);

   logic [mck_pkg::CONC_W-1:0]  conc [2];
   logic [mck_pkg::CONC_W-1:0]  half [2];

   logic [mck_pkg::REM_W-1:0]   rem_ff [2][mck_pkg::DIV_STAGES];
   logic [mck_pkg::REM_W-1:0]   rem_in [2][mck_pkg::DIV_STAGES];
   logic [mck_pkg::DEN_W-1:0]   den_ff [2][mck_pkg::DIV_STAGES];
   logic [mck_pkg::DEN_W-1:0]   den_in [2][mck_pkg::DIV_STAGES];
   logic [mck_pkg::QUO_W-1:0]   quo_ff [2][mck_pkg::DIV_STAGES];
   logic [mck_pkg::QUO_W-1:0]   quo_in [2][mck_pkg::DIV_STAGES];
   logic                        lsb_ff [2];
   logic                        lsb_in [2];
   logic [mck_pkg::REM_W-1:0]   shf    [2][mck_pkg::DIV_STEPS];
   logic                        ge     [2][mck_pkg::DIV_STEPS];

   mck_pkg::side_type           side_ff [mck_pkg::DIV_STAGES];
   mck_pkg::side_type           side_in [mck_pkg::DIV_STAGES];
   logic [mck_pkg::DIV_STAGES-1:0] vld_ff, vld_in;

   assign conc[0] = light_conc;
   assign conc[1] = co2_conc;
   assign half[0] = light_k;
   assign half[1] = co2_k;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         // entry: the dividend is x<<24, so start from x>>1 and feed x[0] next
         rem_in[l][0] = {3'b000, conc[l][mck_pkg::CONC_W-1:1]};
         den_in[l][0] = {1'b0, conc[l]} + {1'b0, half[l]};
         quo_in[l][0] = '0;
         lsb_in[l]    = conc[l][0];
         for (int k = 0; k < mck_pkg::DIV_STEPS; k++) begin
            shf[l][k] = {rem_ff[l][k][mck_pkg::REM_W-2:0], (k == 0) ? lsb_ff[l] : 1'b0};
            ge[l][k]  = shf[l][k] >= {1'b0, den_ff[l][k]};
            rem_in[l][k+1] = ge[l][k] ? (shf[l][k] - {1'b0, den_ff[l][k]}) : shf[l][k];
            den_in[l][k+1] = den_ff[l][k];
            quo_in[l][k+1] = {quo_ff[l][k][mck_pkg::QUO_W-2:0], ge[l][k]};
         end
      end
   end

   always_comb begin
      side_in[0] = entry_side;
      for (int k = 1; k < mck_pkg::DIV_STAGES; k++) begin
         side_in[k] = side_ff[k-1];
      end
   end

   assign vld_in = {vld_ff[mck_pkg::DIV_STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            lsb_ff[l] <= lsb_in[l];
            for (int k = 0; k < mck_pkg::DIV_STAGES; k++) begin
               rem_ff[l][k] <= rem_in[l][k];
               den_ff[l][k] <= den_in[l][k];
               quo_ff[l][k] <= quo_in[l][k];
            end
         end
         for (int k = 0; k < mck_pkg::DIV_STAGES; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // zero affinity with zero concentration gives a zero factor
   assign light_frac = (den_ff[0][mck_pkg::DIV_STAGES-1] == '0) ? '0
                       : quo_ff[0][mck_pkg::DIV_STAGES-1];
   assign co2_frac   = (den_ff[1][mck_pkg::DIV_STAGES-1] == '0) ? '0
                       : quo_ff[1][mck_pkg::DIV_STAGES-1];
   assign exit_side  = side_ff[mck_pkg::DIV_STAGES-1];
   assign out_valid  = vld_ff[mck_pkg::DIV_STAGES-1];

endmodule

FILE: rtl/core/mck_rate.sv
// Nine-stage multiply pipeline: Monod rate, reaction deltas, growth rate and
// saturation to signed Q8.24. Depends on mck_pkg.
module mck_rate (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [mck_pkg::QUO_W-1:0]          light_frac,
   input  logic [mck_pkg::QUO_W-1:0]          co2_frac,
   input  mck_pkg::side_type                  side,
   input  mck_pkg::rate_cfg_type              cfg,
   output logic                               out_valid,
   output logic signed [mck_pkg::RATE_W-1:0]  light_reaction,
   output logic signed [mck_pkg::RATE_W-1:0]  co2_reaction,
   output logic signed [mck_pkg::RATE_W-1:0]  o2_reaction,
   output logic signed [mck_pkg::RATE_W-1:0]  sucrose_reaction,
   output logic signed [mck_pkg::RATE_W-1:0]  growth_rate,
   output logic                               updated
);

   // clamp to the int32 range: fits when the upper bits all match the sign
   function automatic logic [31:0] sat_q824(input logic signed [48:0] v);
      logic [31:0] r;
      if ((v[48:31] == '0) || (v[48:31] == '1)) begin
         r = v[31:0];
      end else if (v[48]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   logic [8:0] vld_ff, vld_in;

   // stage 1
   logic [56:0] prod1;
   logic [31:0] a1_ff, a1_in;
   logic [24:0] fc1_ff;
   mck_pkg::side_type sd1_ff;
   // stage 2
   logic [56:0] prod2;
   logic [31:0] t1_2_ff, t1_2_in;
   mck_pkg::side_type sd2_ff;
   // stage 3
   logic [47:0] t1s_3_ff, t1s_3_in;
   logic [31:0] t1_3_ff;
   mck_pkg::side_type sd3_ff;
   // stage 4
   logic [33:0] t3_4_ff, t3_4_in;
   logic [34:0] sum_4_ff, sum_4_in;
   logic [63:0] wprod;
   logic [47:0] w_4_ff, w_4_in;
   logic [54:0] t2l_4_ff, t2l_4_in;
   logic [52:0] t2h_4_ff, t2h_4_in;
   logic [31:0] t1_4_ff;
   mck_pkg::side_type sd4_ff;
   // stage 5
   logic [66:0] vprod;
   logic [65:0] pprod;
   logic [79:0] t2sum;
   logic [42:0] v_5_ff, v_5_in;
   logic [41:0] p_5_ff, p_5_in;
   logic [29:0] t2_5_ff, t2_5_in;
   logic [52:0] wl_5_ff, wl_5_in, wh_5_ff, wh_5_in;
   logic [31:0] t1_5_ff;
   mck_pkg::side_type sd5_ff;
   // stage 6
   logic [54:0] ul_6_ff, ul_6_in;
   logic [51:0] uh_6_ff, uh_6_in;
   logic [52:0] ql_6_ff, ql_6_in, qh_6_ff, qh_6_in;
   logic [76:0] o2nsum;
   logic [44:0] o2n_6_ff, o2n_6_in;
   logic signed [34:0] g_6_ff, g_6_in;
   mck_pkg::side_type sd6_ff;
   // stage 7
   logic [75:0] usum;
   logic [73:0] qsum;
   logic [46:0] u_7_ff, u_7_in;
   logic [32:0] q_7_ff, q_7_in;
   logic [44:0] o2n_7_ff;
   logic signed [34:0] g_7_ff;
   mck_pkg::side_type sd7_ff;
   // stage 8
   logic [55:0] o2pl_8_ff, o2pl_8_in;
   logic [54:0] o2ph_8_ff, o2ph_8_in;
   logic [64:0] sucprod;
   logic [32:0] suc_8_ff, suc_8_in;
   logic signed [48:0] lightv, co2v;
   logic [31:0] light_8_ff, light_8_in, co2_8_ff, co2_8_in, gr_8_ff, gr_8_in;
   logic [44:0] o2n_8_ff;
   logic ghost_8_ff;
   // stage 9 (output)
   logic [79:0] o2sum;
   logic [46:0] o2pos;
   logic signed [48:0] o2v;
   logic [31:0] light_9_ff, co2_9_ff, o2_9_ff, suc_9_ff, gr_9_ff;
   logic [31:0] o2_9_in, suc_9_in;
   logic upd_9_ff;

   assign vld_in = {vld_ff[7:0], in_valid};

   always_comb begin
      prod1    = {25'b0, cfg.max_growth} * {32'b0, light_frac};
      a1_in    = prod1[55:24];

      prod2    = {25'b0, a1_ff} * {32'b0, fc1_ff};
      t1_2_in  = prod2[55:24];

      t1s_3_in = {16'b0, t1_2_ff} * {32'b0, cfg.suc_export};

      t3_4_in  = t1s_3_ff[47:14];
      sum_4_in = {3'b000, t1_3_ff} + {1'b0, t1s_3_ff[47:14]};
      wprod    = {32'b0, cfg.maint} * {32'b0, sd3_ff.biomass};
      w_4_in   = wprod[63:16];
      t2l_4_in = {30'b0, t1s_3_ff[24:0]} * {25'b0, mck_pkg::K200_Q32};
      t2h_4_in = {30'b0, t1s_3_ff[47:25]} * {23'b0, mck_pkg::K200_Q32};

      vprod    = {35'b0, cfg.inv_yield} * {32'b0, sum_4_ff};
      v_5_in   = vprod[66:24];
      pprod    = {34'b0, cfg.inv_yield} * {32'b0, t3_4_ff};
      p_5_in   = pprod[65:24];
      t2sum    = {25'b0, t2l_4_ff} + {2'b00, t2h_4_ff, 25'b0};
      t2_5_in  = t2sum[77:48];
      wl_5_in  = {29'b0, w_4_ff[23:0]} * {24'b0, mck_pkg::K100_Q32};
      wh_5_in  = {29'b0, w_4_ff[47:24]} * {24'b0, mck_pkg::K100_Q32};

      ul_6_in  = {32'b0, v_5_ff[22:0]} * {23'b0, sd5_ff.biomass};
      uh_6_in  = {32'b0, v_5_ff[42:23]} * {20'b0, sd5_ff.biomass};
      ql_6_in  = {32'b0, p_5_ff[20:0]} * {21'b0, sd5_ff.biomass};
      qh_6_in  = {32'b0, p_5_ff[41:21]} * {21'b0, sd5_ff.biomass};
      o2nsum   = {24'b0, wl_5_ff} + {wh_5_ff, 24'b0};
      o2n_6_in = o2nsum[76:32];
      g_6_in   = $signed({3'b000, t1_5_ff}) - $signed({5'b00000, t2_5_ff})
                 - $signed({3'b000, cfg.decay}) - $signed({3'b000, cfg.maint});

      // hold u below 2^47 and q below 2^33: beyond those the outputs saturate
      usum     = {21'b0, ul_6_ff} + {1'b0, uh_6_ff, 23'b0};
      u_7_in   = (usum[74:63] != '0) ? '1 : usum[62:16];
      qsum     = {21'b0, ql_6_ff} + {qh_6_ff, 21'b0};
      q_7_in   = (qsum[73:49] != '0) ? '1 : qsum[48:16];

      o2pl_8_in = {32'b0, u_7_ff[23:0]} * {24'b0, mck_pkg::K727_Q32};
      o2ph_8_in = {32'b0, u_7_ff[46:24]} * {23'b0, mck_pkg::K727_Q32};
      sucprod   = {32'b0, q_7_ff} * {33'b0, mck_pkg::K650_Q32};
      suc_8_in  = sucprod[64:32];
      lightv    = -$signed({2'b00, u_7_ff});
      co2v      = lightv + (cfg.gas_en ? {{25{sd7_ff.dis[23]}}, sd7_ff.dis} : 49'sd0);
      light_8_in = sat_q824(lightv);
      co2_8_in   = sat_q824(co2v);
      gr_8_in    = sat_q824({{14{g_7_ff[34]}}, g_7_ff});

      o2sum    = {24'b0, o2pl_8_ff} + {1'b0, o2ph_8_ff, 24'b0};
      o2pos    = o2sum[78:32];
      o2v      = $signed({2'b00, o2pos}) - $signed({4'b0000, o2n_8_ff});
      o2_9_in  = sat_q824(o2v);
      suc_9_in = sat_q824($signed({16'b0, suc_8_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff     <= a1_in;
         fc1_ff    <= co2_frac;
         sd1_ff    <= side;
         t1_2_ff   <= t1_2_in;
         sd2_ff    <= sd1_ff;
         t1s_3_ff  <= t1s_3_in;
         t1_3_ff   <= t1_2_ff;
         sd3_ff    <= sd2_ff;
         t3_4_ff   <= t3_4_in;
         sum_4_ff  <= sum_4_in;
         w_4_ff    <= w_4_in;
         t2l_4_ff  <= t2l_4_in;
         t2h_4_ff  <= t2h_4_in;
         t1_4_ff   <= t1_3_ff;
         sd4_ff    <= sd3_ff;
         v_5_ff    <= v_5_in;
         p_5_ff    <= p_5_in;
         t2_5_ff   <= t2_5_in;
         wl_5_ff   <= wl_5_in;
         wh_5_ff   <= wh_5_in;
         t1_5_ff   <= t1_4_ff;
         sd5_ff    <= sd4_ff;
         ul_6_ff   <= ul_6_in;
         uh_6_ff   <= uh_6_in;
         ql_6_ff   <= ql_6_in;
         qh_6_ff   <= qh_6_in;
         o2n_6_ff  <= o2n_6_in;
         g_6_ff    <= g_6_in;
         sd6_ff    <= sd5_ff;
         u_7_ff    <= u_7_in;
         q_7_ff    <= q_7_in;
         o2n_7_ff  <= o2n_6_ff;
         g_7_ff    <= g_6_ff;
         sd7_ff    <= sd6_ff;
         o2pl_8_ff <= o2pl_8_in;
         o2ph_8_ff <= o2ph_8_in;
         suc_8_ff  <= suc_8_in;
         light_8_ff <= light_8_in;
         co2_8_ff  <= co2_8_in;
         gr_8_ff   <= gr_8_in;
         o2n_8_ff  <= o2n_7_ff;
         ghost_8_ff <= sd7_ff.ghost;
         // ghost cells leave every field at zero
         light_9_ff <= ghost_8_ff ? '0 : light_8_ff;
         co2_9_ff   <= ghost_8_ff ? '0 : co2_8_ff;
         o2_9_ff    <= ghost_8_ff ? '0 : o2_9_in;
         suc_9_ff   <= ghost_8_ff ? '0 : suc_9_in;
         gr_9_ff    <= ghost_8_ff ? '0 : gr_8_ff;
         upd_9_ff   <= !ghost_8_ff;
      end
   end

   assign out_valid        = vld_ff[8];
   assign light_reaction   = light_9_ff;
   assign co2_reaction     = co2_9_ff;
   assign o2_reaction      = o2_9_ff;
   assign sucrose_reaction = suc_9_ff;
   assign growth_rate      = gr_9_ff;
   assign updated          = upd_9_ff;

endmodule

FILE: rtl/core/monod_cell_kinetics.sv
// Dual-substrate Monod kinetics for one grid cell per request. Each request
// carries light, dissolved CO2, gas CO2, biomass density and a ghost flag;
// each response carries the light, CO2, O2 and sucrose reaction deltas and
// the specific growth rate in signed Q8.24, saturated, plus an updated flag
// that is low for ghost cells (all fields zero). One request is taken every
// cycle while the response side keeps up; each request passes through the
// restoring dividers for L/(Kl+L) and C/(Kc+C), which resolve one quotient
// bit per stage, and then through the multiply stages. A stalled response
// holds the whole pipeline. There is no state between cells and no clearing
// pass after reset. Registers are written through the csr channel, always
// ready, and should only change while no request is in flight.
// Depends on mck_pkg, mck_if, mck_monod_div and mck_rate.
module monod_cell_kinetics (
   input  logic      clock,
   input  logic      reset,
   mck_req_if.sink   req_chan,
   mck_rsp_if.source rsp_chan,
   mck_csr_if.sink   csr_chan
);

   // configuration registers
   logic [31:0] max_growth_ff, inv_yield_ff, light_k_ff, co2_k_ff, maint_ff, decay_ff;
   logic [15:0] suc_export_ff;
   logic        gas_en_ff;

   logic                  en;
   mck_pkg::side_type     entry_side, div_side;
   mck_pkg::rate_cfg_type rate_cfg;
   logic                  div_valid;
   logic [mck_pkg::QUO_W-1:0] light_frac, co2_frac;
   logic [46:0]           gas_prod, liq_prod;

   // advance the pipeline unless a finished response is being held back
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_growth_ff <= 32'd0;
         inv_yield_ff  <= 32'd16777216;
         light_k_ff    <= 32'd65536;
         co2_k_ff      <= 32'd65536;
         maint_ff      <= 32'd0;
         decay_ff      <= 32'd0;
         suc_export_ff <= 16'd0;
         gas_en_ff     <= 1'b0;
      end else if (csr_chan.valid) begin
         case (mck_pkg::csr_index_type'(csr_chan.reg_index))
            mck_pkg::CSR_MAX_GROWTH: begin
               max_growth_ff <= csr_chan.wdata;
            end
            mck_pkg::CSR_INV_YIELD: begin
               inv_yield_ff <= csr_chan.wdata;
            end
            mck_pkg::CSR_LIGHT_K: begin
               light_k_ff <= csr_chan.wdata;
            end
            mck_pkg::CSR_CO2_K: begin
               co2_k_ff <= csr_chan.wdata;
            end
            mck_pkg::CSR_MAINT: begin
               maint_ff <= csr_chan.wdata;
            end
            mck_pkg::CSR_DECAY: begin
               decay_ff <= csr_chan.wdata;
            end
            mck_pkg::CSR_SUC_EXPORT: begin
               suc_export_ff <= csr_chan.wdata[15:0];
            end
            mck_pkg::CSR_GAS_EN: begin
               gas_en_ff <= csr_chan.wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // dissolution term (G*KD>>24) - (C*KD>>24), registered at divider entry
   assign gas_prod = {15'b0, req_chan.gas_co2_conc} * {32'b0, mck_pkg::KD_Q32};
   assign liq_prod = {15'b0, req_chan.co2_conc} * {32'b0, mck_pkg::KD_Q32};

   always_comb begin
      entry_side.ghost   = req_chan.ghost_cell;
      entry_side.biomass = req_chan.biomass_density;
      entry_side.dis     = $signed({1'b0, gas_prod[46:24]}) - $signed({1'b0, liq_prod[46:24]});
   end

   always_comb begin
      rate_cfg.max_growth = max_growth_ff;
      rate_cfg.inv_yield  = inv_yield_ff;
      rate_cfg.maint      = maint_ff;
      rate_cfg.decay      = decay_ff;
      rate_cfg.suc_export = suc_export_ff;
      rate_cfg.gas_en     = gas_en_ff;
   end

   mck_monod_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_chan.valid),
      .light_conc (req_chan.light_conc),
      .co2_conc   (req_chan.co2_conc),
      .light_k    (light_k_ff),
      .co2_k      (co2_k_ff),
      .entry_side (entry_side),
      .out_valid  (div_valid),
      .light_frac (light_frac),
      .co2_frac   (co2_frac),
      .exit_side  (div_side)
   );

   mck_rate u_rate (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (div_valid),
      .light_frac       (light_frac),
      .co2_frac         (co2_frac),
      .side             (div_side),
      .cfg              (rate_cfg),
      .out_valid        (rsp_chan.valid),
      .light_reaction   (rsp_chan.light_reaction),
      .co2_reaction     (rsp_chan.co2_reaction),
      .o2_reaction      (rsp_chan.o2_reaction),
      .sucrose_reaction (rsp_chan.sucrose_reaction),
      .growth_rate      (rsp_chan.growth_rate),
      .updated          (rsp_chan.updated)
   );

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   // a ghost cell gives all-zero deltas
   a_ghost_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.updated) |->
         (rsp_chan.light_reaction == 0 && rsp_chan.co2_reaction == 0 &&
          rsp_chan.o2_reaction == 0 && rsp_chan.sucrose_reaction == 0 &&
          rsp_chan.growth_rate == 0))
      else $error("ghost response carries non-zero fields");

   // light is only consumed
   a_light_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.light_reaction[31] || rsp_chan.light_reaction == 0))
      else $error("positive light reaction");

   // sucrose is only produced
   a_suc_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !rsp_chan.sucrose_reaction[31])
      else $error("negative sucrose reaction");

endmodule

FILE: tb/sv/monod_cell_kinetics_test.sv
// Self-checking testbench for monod_cell_kinetics: drives cells through the request
// channel, predicts each response in fixed point and compares it field by field.
// Depends on mck_pkg, mck_if and the monod_cell_kinetics RTL.
module monod_cell_kinetics_test;

   localparam logic [63:0] CAP62     = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam int          DRAIN_CYC = 45;       // pipeline latency plus margin
   localparam int          LIMIT_CYC = 600000;

   typedef struct {
      logic [31:0] light;
      logic [31:0] co2;
      logic [31:0] gas;
      logic [31:0] biomass;
      logic        ghost;
   } cell_type;

   typedef struct {
      logic signed [31:0] light_rx;
      logic signed [31:0] co2_rx;
      logic signed [31:0] o2_rx;
      logic signed [31:0] sucrose_rx;
      logic signed [31:0] growth;
      logic               updated;
   } deltas_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mck_req_if req_chan ();
   mck_rsp_if rsp_chan ();
   mck_csr_if csr_chan ();

   monod_cell_kinetics DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // shadow copy of the register file, as the block should hold it
   logic [31:0] kin_cfg [8];

   deltas_type pending_deltas [$];
   int      error_count   = 0;
   int      cells_sent    = 0;
   int      cells_checked = 0;
   int      ghosts_sent   = 0;
   int      cycle_count   = 0;
   int      burst_left    = 0;
   bit      gaps_on       = 1'b1;
   int      hold_left     = 0;    // long receiver hold-off, counted below
   int      stall_style   = 0;
   int      style_left    = 0;
   int      pattern_phase = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Drive every input to a known value from time zero.
   initial begin
      req_chan.valid           = 1'b0;
      req_chan.light_conc      = '0;
      req_chan.co2_conc        = '0;
      req_chan.gas_co2_conc    = '0;
      req_chan.biomass_density = '0;
      req_chan.ghost_cell      = 1'b0;
      rsp_chan.ready           = 1'b0;
      csr_chan.valid           = 1'b0;
      csr_chan.reg_index       = '0;
      csr_chan.wdata           = '0;
   end

   // Watchdog: end the run if it overruns the generous limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYC) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_deltas.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   // floor(a*b / 2^sh) over the full product, capped at 2^62-1
   function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> sh;
      return (p > {64'd0, CAP62}) ? CAP62 : p[63:0];
   endfunction

   // x/(k+x) in Q0.24, zero for a zero denominator
   function automatic logic [63:0] monod_factor(logic [31:0] x, logic [31:0] k);
      logic [63:0] den;
      den = {32'd0, x} + {32'd0, k};
      if (den == 64'd0) return 64'd0;
      return ({32'd0, x} << 24) / den;
   endfunction

   function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647)  return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic deltas_type predict_deltas(cell_type c);
      deltas_type         d;
      logic [63:0]        mu, iy, m, b, s, fl, fc, t1, t3, u, o2p, o2n, suc, t2;
      logic signed [63:0] co2;
      mu = {32'd0, kin_cfg[mck_pkg::CSR_MAX_GROWTH]};
      iy = {32'd0, kin_cfg[mck_pkg::CSR_INV_YIELD]};
      m  = {32'd0, kin_cfg[mck_pkg::CSR_MAINT]};
      b  = {32'd0, kin_cfg[mck_pkg::CSR_DECAY]};
      s  = {48'd0, kin_cfg[mck_pkg::CSR_SUC_EXPORT][15:0]};
      if (c.ghost) begin
         d = '{default: '0};
         return d;
      end
      fl  = monod_factor(c.light, kin_cfg[mck_pkg::CSR_LIGHT_K]);
      fc  = monod_factor(c.co2, kin_cfg[mck_pkg::CSR_CO2_K]);
      t1  = scaled_product(scaled_product(mu, fl, 24), fc, 24);
      t3  = (64'd4 * t1 * s) >> 16;
      u   = scaled_product(scaled_product(iy, t1 + t3, 24), {32'd0, c.biomass}, 16);
      co2 = -$signed(u);
      if (kin_cfg[mck_pkg::CSR_GAS_EN][0])
         co2 = co2 + $signed(({32'd0, c.gas} * 64'd18898) >> 24)
                   - $signed(({32'd0, c.co2} * 64'd18898) >> 24);
      o2p = scaled_product(u, 64'd3122441224, 32);
      o2n = scaled_product(scaled_product(m, {32'd0, c.biomass}, 16), 64'd429496730, 32);
      suc = scaled_product(scaled_product(scaled_product(iy, t3, 24),
                                          {32'd0, c.biomass}, 16), 64'd2791728742, 32);
      t2  = scaled_product(t1 * s, 64'd858993459, 48);
      d.light_rx   = clamp32(-$signed(u));
      d.co2_rx     = clamp32(co2);
      d.o2_rx      = clamp32($signed(o2p) - $signed(o2n));
      d.sucrose_rx = clamp32($signed(suc));
      d.growth     = clamp32($signed(t1) - $signed(t2) - $signed(b) - $signed(m));
      d.updated    = 1'b1;
      return d;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= 30)
         $display("mismatch at cycle %0d: %s got %h expected %h",
                  cycle_count, what, got, want);
   endtask

   always @(posedge clock) begin
      deltas_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_deltas.size() == 0) begin
            report_mismatch("unexpected response", 32'd0, 32'd0);
         end else begin
            want = pending_deltas.pop_front();
            cells_checked++;
            if (rsp_chan.light_reaction !== want.light_rx)
               report_mismatch("light_reaction", rsp_chan.light_reaction, want.light_rx);
            if (rsp_chan.co2_reaction !== want.co2_rx)
               report_mismatch("co2_reaction", rsp_chan.co2_reaction, want.co2_rx);
            if (rsp_chan.o2_reaction !== want.o2_rx)
               report_mismatch("o2_reaction", rsp_chan.o2_reaction, want.o2_rx);
            if (rsp_chan.sucrose_reaction !== want.sucrose_rx)
               report_mismatch("sucrose_reaction", rsp_chan.sucrose_reaction,
                               want.sucrose_rx);
            if (rsp_chan.growth_rate !== want.growth)
               report_mismatch("growth_rate", rsp_chan.growth_rate, want.growth);
            if (rsp_chan.updated !== want.updated)
               report_mismatch("updated", {31'd0, rsp_chan.updated},
                               {31'd0, want.updated});
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // Count down a long hold-off in its own process.
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // Stall pattern: switch style every so often between always ready, coin-toss,
   // a periodic on/off rhythm and a rare drop; drop ready during a hold-off.
   always @(negedge clock) begin
      logic rdy;
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 3);
         style_left  = $urandom_range(20, 300);
      end else begin
         style_left = style_left - 1;
      end
      pattern_phase = pattern_phase + 1;
      case (stall_style)
         0: begin
            rdy = 1'b1;
         end
         1: begin
            rdy = 1'($urandom_range(0, 1));
         end
         2: begin
            rdy = (pattern_phase % 7) < 4;
         end
         default: begin
            rdy = $urandom_range(0, 9) != 0;
         end
      endcase
      rsp_chan.ready <= rdy && (hold_left == 0) && !reset;
   end

   // ---------------------------------------------------------------- sender

   // Offer one cell; hold it until accepted, then record the prediction.
   task automatic send_cell(cell_type c);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on) begin
            gap = $urandom_range(1, 6);
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid           <= 1'b1;
      req_chan.light_conc      <= c.light;
      req_chan.co2_conc        <= c.co2;
      req_chan.gas_co2_conc    <= c.gas;
      req_chan.biomass_density <= c.biomass;
      req_chan.ghost_cell      <= c.ghost;
      do @(posedge clock); while (!req_chan.ready);
      pending_deltas.push_back(predict_deltas(c));
      cells_sent++;
      if (c.ghost) ghosts_sent++;
   endtask

   // Drop valid, wait for every response, then let the pipeline settle.
   task automatic drain_pipeline();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_deltas.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic write_register(mck_pkg::csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wdata     <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         mck_pkg::CSR_SUC_EXPORT: kin_cfg[idx] = {16'd0, data[15:0]};
         mck_pkg::CSR_GAS_EN:     kin_cfg[idx] = {31'd0, data[0]};
         default:                 kin_cfg[idx] = data;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic load_settings(logic [31:0] mu, logic [31:0] iy, logic [31:0] kl,
                                logic [31:0] kc, logic [31:0] m, logic [31:0] b,
                                logic [31:0] s, logic [31:0] gas);
      write_register(mck_pkg::CSR_MAX_GROWTH, mu);
      write_register(mck_pkg::CSR_INV_YIELD, iy);
      write_register(mck_pkg::CSR_LIGHT_K, kl);
      write_register(mck_pkg::CSR_CO2_K, kc);
      write_register(mck_pkg::CSR_MAINT, m);
      write_register(mck_pkg::CSR_DECAY, b);
      write_register(mck_pkg::CSR_SUC_EXPORT, s);
      write_register(mck_pkg::CSR_GAS_EN, gas);
   endtask

   // Concentrations: mostly moderate, sometimes full range or an extreme.
   function automatic logic [31:0] pick_conc();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return $urandom_range(0, 32'h0000_FFFF);
         2:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         3:       return $urandom_range(0, 32'h00FF_FFFF);
         default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
      endcase
   endfunction

   function automatic logic [31:0] pick_rate();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return 32'h0;
         2:       return $urandom_range(0, 32'h0200_0000);
         default: return $urandom_range(0, 32'h0040_0000);
      endcase
   endfunction

   function automatic cell_type random_cell();
      cell_type c;
      c.light   = pick_conc();
      c.co2     = pick_conc();
      c.gas     = pick_conc();
      c.biomass = pick_conc();
      c.ghost   = ($urandom_range(0, 9) == 0);
      return c;
   endfunction

   task automatic random_settings();
      load_settings(pick_rate(), pick_rate(), pick_conc(), pick_conc(), pick_rate(),
                    pick_rate(), $urandom, $urandom);
   endtask

   task automatic send_directed(logic [31:0] l, logic [31:0] c, logic [31:0] g,
                                logic [31:0] x, logic gh);
      cell_type item;
      item = '{light: l, co2: c, gas: g, biomass: x, ghost: gh};
      send_cell(item);
   endtask

   // ---------------------------------------------------------------- tests

   // Reset values of the registers, then a plain mid-range setting.
   task automatic test_reset_and_extremes();
      send_directed(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
      send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      drain_pipeline();
      load_settings(32'h0100_0000, 32'h0200_0000, 32'h0001_0000, 32'h0002_0000,
                    32'h0004_0000, 32'h0002_0000, 32'h0000_4000, 32'd1);
      send_directed(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_directed(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
      send_directed(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000, 1'b0);
      send_directed(32'h0002_0000, 32'h0003_0000, 32'h0100_0000, 32'h0010_0000, 1'b0);
      // ghost cells: all-zero response whatever the inputs
      send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_directed(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      drain_pipeline();
   endtask

   // Zero affinity with zero concentration gives a zero Monod factor.
   task automatic test_zero_affinity();
      load_settings(32'hFFFF_FFFF, 32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                    32'h0, 32'h0);
      send_directed(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
      send_directed(32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
      send_directed(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
      send_directed(32'h0000_0001, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 1'b0);
      drain_pipeline();
   endtask

   // Every register at its maximum, then high rates with zero affinities, to push the outputs into saturation;
   // high bits of the narrow registers are written and must be ignored.
   task automatic test_saturation();
      load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
      send_directed(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      drain_pipeline();
      load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
                    32'hFFFE_0000, 32'hFFFF_FFFE);
      send_directed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_directed(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0000_0100, 1'b0);
      drain_pipeline();
   endtask

   // Hold the receiver off for a long stretch while cells keep coming, so the
   // pipeline fills and the request side stalls.
   task automatic test_backpressure();
      load_settings(32'h0180_0000, 32'h0180_0000, 32'h0000_8000, 32'h0001_8000,
                    32'h0001_0000, 32'h0000_8000, 32'h0000_8000, 32'd1);
      gaps_on   = 1'b0;
      hold_left = 400;
      repeat (150) send_cell(random_cell());
      gaps_on = 1'b1;
      drain_pipeline();
   endtask

   // Random cells under a string of random settings, some with no gaps.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 10; phase++) begin
         random_settings();
         gaps_on = (phase % 3) != 0;
         repeat (120) send_cell(random_cell());
         drain_pipeline();
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      kin_cfg[mck_pkg::CSR_MAX_GROWTH] = 32'd0;
      kin_cfg[mck_pkg::CSR_INV_YIELD]  = 32'd16777216;
      kin_cfg[mck_pkg::CSR_LIGHT_K]    = 32'd65536;
      kin_cfg[mck_pkg::CSR_CO2_K]      = 32'd65536;
      kin_cfg[mck_pkg::CSR_MAINT]      = 32'd0;
      kin_cfg[mck_pkg::CSR_DECAY]      = 32'd0;
      kin_cfg[mck_pkg::CSR_SUC_EXPORT] = 32'd0;
      kin_cfg[mck_pkg::CSR_GAS_EN]     = 32'd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_and_extremes();
      test_zero_affinity();
      test_saturation();
      test_backpressure();
      test_random_traffic();

      $display("covered %0d cells (%0d ghost), %0d responses checked",
               cells_sent, ghosts_sent, cells_checked);
      $display("settings: reset values, zero affinity, saturation, back-pressure, random");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
